// ===== src/hsv2rgb_pkg.sv =====
// Shared constants and pipeline payload types for the HSV to RGB converter.
package hsv2rgb_pkg;

   localparam int HUE_W = 15;
   localparam int CHAN_W = 8;
   localparam int FRAC_W = 12;
   localparam int NUM_W = 20;
   localparam int LANES = 3;

   localparam logic [HUE_W-1:0] HUE_FULL = 15'd23040;
   localparam logic [HUE_W-1:0] HUE_SECTOR = 15'd3840;
   localparam logic [FRAC_W-1:0] SECTOR_SPAN = 12'd3840;
   localparam logic [CHAN_W-1:0] UNIT = 8'd255;
   localparam logic [NUM_W-1:0] FULL_SCALE = 20'd979200;
   localparam logic [FRAC_W-1:0] DIV_BASE = 12'd3825;
   localparam logic [63:0] RECIP_WIDE = 64'h1_0000_0000 / 64'd3825;
   localparam int RECIP_W = 21;
   localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_WIDE[RECIP_W-1:0];

   localparam int LANE_P = 0;
   localparam int LANE_Q = 1;
   localparam int LANE_T = 2;

   typedef enum logic [2:0] {
      SECTOR_0,
      SECTOR_1,
      SECTOR_2,
      SECTOR_3,
      SECTOR_4,
      SECTOR_5
   } sector_type;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [CHAN_W-1:0] sat;
      logic [CHAN_W-1:0] val;
   } hsv_type;

   typedef struct packed {
      sector_type        sector;
      logic [FRAC_W-1:0] frac;
      logic [CHAN_W-1:0] sat;
      logic [CHAN_W-1:0] val;
   } sect_type;

   typedef struct packed {
      sector_type                  sector;
      logic [CHAN_W-1:0]           val;
      logic [LANES-1:0][NUM_W-1:0] x;
   } num_type;

   typedef struct packed {
      sector_type                   sector;
      logic [CHAN_W-1:0]            val;
      logic [LANES-1:0][CHAN_W-1:0] q;
   } chan_type;

endpackage

// ===== src/hsv2rgb_ifs.sv =====
// Valid/ready channel interfaces for the HSV request word and the RGB response word.
interface hsv2rgb_req_if;
   logic       valid;
   logic       ready;
   logic [14:0] hue;
   logic [7:0] saturation;
   logic [7:0] brightness;

   modport source(output valid, output hue, output saturation, output brightness,
                  input ready);
   modport sink(input valid, input hue, input saturation, input brightness,
                output ready);
endinterface

interface hsv2rgb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source(output valid, output red, output green, output blue, input ready);
   modport sink(input valid, input red, input green, input blue, output ready);
endinterface

// ===== src/hsv2rgb_sector.sv =====
// Hue wrap and sector split stages of the HSV to RGB pipeline.
module hsv2rgb_sector (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hsv2rgb_pkg::hsv_type  in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hsv2rgb_pkg::sect_type out_data
);
   import hsv2rgb_pkg::*;

   logic              wrap_valid_ff;
   hsv_type           wrap_ff;
   hsv_type           wrap_in;
   logic              sect_valid_ff;
   sect_type          sect_ff;
   sect_type          sect_in;
   logic              wrap_ready;
   logic              sect_ready;
   logic [2:0]        sec_idx;
   logic [HUE_W-1:0]  base;
   logic [HUE_W-1:0]  frac_full;

   assign sect_ready = !sect_valid_ff || out_ready;
   assign wrap_ready = !wrap_valid_ff || sect_ready;
   assign in_ready = wrap_ready;

   always_comb begin
      wrap_in = in_data;
      if (in_data.hue >= HUE_FULL) begin
         wrap_in.hue = in_data.hue - HUE_FULL;
      end
   end

   always_comb begin
      sec_idx = 3'd0;
      base = '0;
      for (int k = 1; k < 6; k++) begin
         if (wrap_ff.hue >= HUE_W'(k * HUE_SECTOR)) begin
            sec_idx = 3'(k);
            base = HUE_W'(k * HUE_SECTOR);
         end
      end
      frac_full = wrap_ff.hue - base;
      sect_in.sector = sector_type'(sec_idx);
      sect_in.frac = frac_full[FRAC_W-1:0];
      sect_in.sat = wrap_ff.sat;
      sect_in.val = wrap_ff.val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_valid_ff <= 1'b0;
         sect_valid_ff <= 1'b0;
      end else begin
         if (wrap_ready) begin
            wrap_valid_ff <= in_valid;
         end
         if (sect_ready) begin
            sect_valid_ff <= wrap_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wrap_ready && in_valid) begin
         wrap_ff <= wrap_in;
      end
      if (sect_ready && wrap_valid_ff) begin
         sect_ff <= sect_in;
      end
   end

   assign out_valid = sect_valid_ff;
   assign out_data = sect_ff;

   // The fraction left after the sector split must stay inside one sector.
   frac_in_range: assert property (@(posedge clock) disable iff (reset)
      sect_valid_ff |-> (sect_ff.frac < SECTOR_SPAN))
      else $error("sector fraction out of range");

endmodule

// ===== src/hsv2rgb_scale.sv =====
// Product stages that form the scaled p, q and t numerators of the pipeline.
module hsv2rgb_scale (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hsv2rgb_pkg::sect_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hsv2rgb_pkg::num_type  out_data
);
   import hsv2rgb_pkg::*;

   logic                  mul_valid_ff;
   num_type               mul_ff;
   num_type               mul_in;
   logic                  num_valid_ff;
   num_type               num_ff;
   num_type               num_in;
   logic                  mul_ready;
   logic                  num_ready;
   logic [FRAC_W-1:0]     rest_span;
   logic [NUM_W-1:0]      fs_prod;
   logic [NUM_W-1:0]      gs_prod;
   logic [NUM_W-1:0]      ps_prod;
   logic [LANES-1:0][27:0] wide_prod;

   assign num_ready = !num_valid_ff || out_ready;
   assign mul_ready = !mul_valid_ff || num_ready;
   assign in_ready = mul_ready;

   always_comb begin
      rest_span = SECTOR_SPAN - in_data.frac;
      fs_prod = NUM_W'(in_data.frac) * NUM_W'(in_data.sat);
      gs_prod = NUM_W'(rest_span) * NUM_W'(in_data.sat);
      ps_prod = NUM_W'(UNIT - in_data.sat) * NUM_W'(SECTOR_SPAN);
      mul_in.sector = in_data.sector;
      mul_in.val = in_data.val;
      mul_in.x[LANE_P] = ps_prod;
      mul_in.x[LANE_Q] = FULL_SCALE - fs_prod;
      mul_in.x[LANE_T] = FULL_SCALE - gs_prod;
   end

   always_comb begin
      num_in.sector = mul_ff.sector;
      num_in.val = mul_ff.val;
      for (int i = 0; i < LANES; i++) begin
         wide_prod[i] = 28'(mul_ff.val) * 28'(mul_ff.x[i]);
         num_in.x[i] = wide_prod[i][27:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         num_valid_ff <= 1'b0;
      end else begin
         if (mul_ready) begin
            mul_valid_ff <= in_valid;
         end
         if (num_ready) begin
            num_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && in_valid) begin
         mul_ff <= mul_in;
      end
      if (num_ready && mul_valid_ff) begin
         num_ff <= num_in;
      end
   end

   assign out_valid = num_valid_ff;
   assign out_data = num_ff;

endmodule

// ===== src/hsv2rgb_div.sv =====
// Constant divider stages: reciprocal estimate, then a one-step remainder correction.
module hsv2rgb_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hsv2rgb_pkg::num_type  in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hsv2rgb_pkg::chan_type out_data
);
   import hsv2rgb_pkg::*;

   typedef struct packed {
      sector_type                   sector;
      logic [CHAN_W-1:0]            val;
      logic [LANES-1:0][NUM_W-1:0]  x;
      logic [LANES-1:0][CHAN_W-1:0] qa;
   } est_type;

   localparam int PROD_W = NUM_W + RECIP_W;

   logic                        est_valid_ff;
   est_type                     est_ff;
   est_type                     est_in;
   logic                        quo_valid_ff;
   chan_type                    quo_ff;
   chan_type                    quo_in;
   logic                        est_ready;
   logic                        quo_ready;
   logic [LANES-1:0][PROD_W-1:0] recip_prod;
   logic [LANES-1:0][NUM_W-1:0]  rem;

   assign quo_ready = !quo_valid_ff || out_ready;
   assign est_ready = !est_valid_ff || quo_ready;
   assign in_ready = est_ready;

   always_comb begin
      est_in.sector = in_data.sector;
      est_in.val = in_data.val;
      est_in.x = in_data.x;
      for (int i = 0; i < LANES; i++) begin
         recip_prod[i] = PROD_W'(in_data.x[i]) * PROD_W'(DIV_RECIP);
         est_in.qa[i] = recip_prod[i][39:32];
      end
   end

   always_comb begin
      quo_in.sector = est_ff.sector;
      quo_in.val = est_ff.val;
      for (int i = 0; i < LANES; i++) begin
         rem[i] = est_ff.x[i] - NUM_W'(est_ff.qa[i]) * NUM_W'(DIV_BASE);
         if (rem[i] >= NUM_W'(DIV_BASE)) begin
            quo_in.q[i] = est_ff.qa[i] + 8'd1;
         end else begin
            quo_in.q[i] = est_ff.qa[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_valid_ff <= 1'b0;
         quo_valid_ff <= 1'b0;
      end else begin
         if (est_ready) begin
            est_valid_ff <= in_valid;
         end
         if (quo_ready) begin
            quo_valid_ff <= est_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (est_ready && in_valid) begin
         est_ff <= est_in;
      end
      if (quo_ready && est_valid_ff) begin
         quo_ff <= quo_in;
      end
   end

   assign out_valid = quo_valid_ff;
   assign out_data = quo_ff;

   // The reciprocal estimate may fall short by at most one, never more.
   estimate_close: assert property (@(posedge clock) disable iff (reset)
      est_valid_ff |-> (rem[LANE_P] < NUM_W'(2 * DIV_BASE))
                    && (rem[LANE_Q] < NUM_W'(2 * DIV_BASE))
                    && (rem[LANE_T] < NUM_W'(2 * DIV_BASE)))
      else $error("reciprocal estimate off by more than one");

endmodule

// ===== src/hsv_to_rgb_converter_unit.sv =====
// Top level of the HSV to RGB converter: pipeline assembly, channel select and output register.
//
// The req_chan word carries a hue in 1/64-degree units (23040 is a full turn; values
// from 23040 upward are wrapped once), an 8-bit saturation and an 8-bit brightness.
// The rsp_chan word carries the 8-bit red, green and blue channels.
// Both channels use valid/ready; a word moves on a rising edge with both high.
// The pipeline has seven register stages: hue wrap, sector split, span products,
// brightness products, reciprocal estimate, remainder correction and the output
// register that also picks the channels by sector.
// An accepted word passes through every stage in order and is presented on rsp_chan from the output register.
// One word is accepted every cycle while the receiver takes results; the seven
// stages with their valid bits bound the words in flight.
// When the receiver stalls, each stage holds its word and empty stages keep
// filling, so req_chan stays ready until the pipeline is full.
// Synchronous reset empties the pipeline; no word is presented after it.
module hsv_to_rgb_converter_unit (
   input  logic clock,
   input  logic reset,
   hsv2rgb_req_if.sink   req_chan,
   hsv2rgb_rsp_if.source rsp_chan
);
   import hsv2rgb_pkg::*;

   hsv_type           req_data;
   logic              sect_valid;
   logic              sect_ready;
   sect_type          sect_data;
   logic              num_valid;
   logic              num_ready;
   num_type           num_data;
   logic              chan_valid;
   logic              chan_ready;
   chan_type          chan_data;
   logic              out_valid_ff;
   logic [CHAN_W-1:0] red_ff;
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_ff;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_ff;
   logic [CHAN_W-1:0] blue_in;

   assign req_data.hue = req_chan.hue;
   assign req_data.sat = req_chan.saturation;
   assign req_data.val = req_chan.brightness;

   hsv2rgb_sector u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_data   (req_data),
      .out_valid (sect_valid),
      .out_ready (sect_ready),
      .out_data  (sect_data)
   );

   hsv2rgb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sect_valid),
      .in_ready  (sect_ready),
      .in_data   (sect_data),
      .out_valid (num_valid),
      .out_ready (num_ready),
      .out_data  (num_data)
   );

   hsv2rgb_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (num_valid),
      .in_ready  (num_ready),
      .in_data   (num_data),
      .out_valid (chan_valid),
      .out_ready (chan_ready),
      .out_data  (chan_data)
   );

   assign chan_ready = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      case (chan_data.sector)
         SECTOR_0: begin
            red_in = chan_data.val;
            green_in = chan_data.q[LANE_T];
            blue_in = chan_data.q[LANE_P];
         end
         SECTOR_1: begin
            red_in = chan_data.q[LANE_Q];
            green_in = chan_data.val;
            blue_in = chan_data.q[LANE_P];
         end
         SECTOR_2: begin
            red_in = chan_data.q[LANE_P];
            green_in = chan_data.val;
            blue_in = chan_data.q[LANE_T];
         end
         SECTOR_3: begin
            red_in = chan_data.q[LANE_P];
            green_in = chan_data.q[LANE_Q];
            blue_in = chan_data.val;
         end
         SECTOR_4: begin
            red_in = chan_data.q[LANE_T];
            green_in = chan_data.q[LANE_P];
            blue_in = chan_data.val;
         end
         default: begin
            red_in = chan_data.val;
            green_in = chan_data.q[LANE_P];
            blue_in = chan_data.q[LANE_Q];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (chan_ready) begin
         out_valid_ff <= chan_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (chan_ready && chan_valid) begin
         red_ff <= red_in;
         green_ff <= green_in;
         blue_ff <= blue_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.red = red_ff;
   assign rsp_chan.green = green_ff;
   assign rsp_chan.blue = blue_ff;

   // No derived channel may exceed the brightness.
   chan_below_val: assert property (@(posedge clock) disable iff (reset)
      chan_valid |-> (chan_data.q[LANE_P] <= chan_data.val)
                  && (chan_data.q[LANE_Q] <= chan_data.val)
                  && (chan_data.q[LANE_T] <= chan_data.val))
      else $error("derived channel above brightness");

   // A full output register that is not taken must hold back the stage behind it.
   stall_holds_back: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready) |-> !chan_ready)
      else $error("divider stage not held during output stall");

   // Reset leaves no word on the response side.
   reset_empties: assert property (@(posedge clock)
      reset |=> !out_valid_ff)
      else $error("response valid after reset");

endmodule
